[rtl/core/h264_auto_level_select_top_defines.svh]
// assertion macros for the level select block
`ifndef H264_AUTO_LEVEL_SELECT_TOP_DEFINES_SVH
`define H264_AUTO_LEVEL_SELECT_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HALS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("level select check failed");

// next-cycle implication, checked out of reset
`define HALS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("level select check failed");

`endif

[rtl/core/hals_pkg.sv]
package hals_pkg;

    // level table shape
    localparam int LVL_ROWS = 17;
    localparam int LVL_COLS = 6;
    localparam int ROW_W    = $clog2(LVL_ROWS + 1);
    localparam int COL_W    = $clog2(LVL_COLS + 1);

    // datapath widths
    localparam int MB_W     = 11;
    localparam int MBF_W    = 21;
    localparam int NUM_W    = 20;
    localparam int REF_W    = 5;
    localparam int DPB_W    = MBF_W + REF_W;
    localparam int PROD_W   = 40;
    localparam int DEM_W    = 40;
    localparam int VBV_W    = 24;
    localparam int CELL_W   = 24;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W    = $clog2(DIV_STEPS);

    // column codes of the level table
    localparam logic [COL_W-1:0] COL_ILACE = 3'd0;
    localparam logic [COL_W-1:0] COL_MBPS  = 3'd1;
    localparam logic [COL_W-1:0] COL_FS    = 3'd2;
    localparam logic [COL_W-1:0] COL_DPB   = 3'd3;
    localparam logic [COL_W-1:0] COL_VBVR  = 3'd4;
    localparam logic [COL_W-1:0] COL_VBVS  = 3'd5;

    typedef logic [CELL_W-1:0] cell_t;

    // interlace limit, max mbps, max fs, max dpb mbs, vbv rate, vbv buffer
    localparam cell_t LVL_TABLE [LVL_ROWS][LVL_COLS] = '{
        '{24'd1,    24'd1485,   24'd99,    24'd396,    24'd64,     24'd175},
        '{24'd1,    24'd1485,   24'd99,    24'd396,    24'd128,    24'd350},
        '{24'd1,    24'd3000,   24'd396,   24'd900,    24'd192,    24'd500},
        '{24'd1,    24'd6000,   24'd396,   24'd2376,   24'd384,    24'd1000},
        '{24'd1,    24'd11880,  24'd396,   24'd2376,   24'd768,    24'd2000},
        '{24'd1,    24'd11880,  24'd396,   24'd2376,   24'd2000,   24'd2000},
        '{24'd2,    24'd19800,  24'd792,   24'd4752,   24'd4000,   24'd4000},
        '{24'd2,    24'd20250,  24'd1620,  24'd8100,   24'd4000,   24'd4000},
        '{24'd2,    24'd40500,  24'd1620,  24'd8100,   24'd10000,  24'd10000},
        '{24'd2,    24'd108000, 24'd3600,  24'd18000,  24'd14000,  24'd14000},
        '{24'd2,    24'd216000, 24'd5120,  24'd20480,  24'd20000,  24'd20000},
        '{24'd2,    24'd245760, 24'd8192,  24'd32768,  24'd20000,  24'd25000},
        '{24'd2,    24'd245760, 24'd8192,  24'd32768,  24'd50000,  24'd62500},
        '{24'd2,    24'd522240, 24'd8704,  24'd34816,  24'd50000,  24'd62500},
        '{24'd1,    24'd589824, 24'd22080, 24'd110400, 24'd135000, 24'd135000},
        '{24'd1,    24'd983040, 24'd36864, 24'd184320, 24'd240000, 24'd240000},
        '{24'd1,    24'd2073600,24'd36864, 24'd184320, 24'd240000, 24'd240000}
    };

endpackage

[rtl/core/h264_auto_level_select_top.sv]
// H.264 level selection for one stream setup.
// A request is taken when start is high and busy is low; all request fields
// (picture size, reference count, interlace flag, frame rate fraction, vbv
// rate and buffer) are sampled in that cycle. busy then stays high until the
// answer is out, and start is ignored meanwhile.
// The answer level_index appears for exactly one cycle with done high; the
// receiver has no way to stall it and must take it in that cycle.
// From the accepting edge to the done cycle the block makes three passes
// through one shared 21x20 multiplier (frame size, pixel rate product, dpb
// size), runs a restoring divider (one quotient bit per cycle) for the
// ceiling of macroblocks per second, then walks the staircase, one table
// cell compared per cycle.
// busy drops in the done cycle, so a new request may be taken at the edge
// that ends the done cycle; no new request is taken while one is in flight.
// Reset returns the sequencer to idle with busy and done low; no item in
// flight survives it.
`include "h264_auto_level_select_top_defines.svh"

module h264_auto_level_select_top
    import hals_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [13:0]         pic_width,
    input  logic [13:0]         pic_height,
    input  logic [REF_W-1:0]    ref_count,
    input  logic                is_interlaced,
    input  logic [NUM_W-1:0]    rate_num,
    input  logic [NUM_W-1:0]    rate_den,
    input  logic [VBV_W-1:0]    vbv_rate,
    input  logic [VBV_W-1:0]    vbv_size,
    output logic                done,
    output logic [4:0]          level_index
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_FS,
        ST_MUL_MBPS,
        ST_MUL_DPB,
        ST_DIV,
        ST_WALK
    } state_t;

    state_t             state_reg, state_next;
    logic [MB_W-1:0]    wmb_reg, wmb_next;
    logic [MB_W-1:0]    hmb_reg, hmb_next;
    logic [MBF_W-1:0]   mbf_reg, mbf_next;
    logic [DPB_W-1:0]   dpb_reg, dpb_next;
    logic [PROD_W-1:0]  dq_reg, dq_next;
    logic [NUM_W:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [NUM_W-1:0]   den_reg, den_next;
    logic [REF_W-1:0]   refs_reg, refs_next;
    logic               ilace_reg, ilace_next;
    logic [VBV_W-1:0]   vrate_reg, vrate_next;
    logic [VBV_W-1:0]   vsize_reg, vsize_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic               done_reg, done_next;
    logic [4:0]         level_reg, level_next;

    logic [MBF_W-1:0]   mul_a;
    logic [NUM_W-1:0]   mul_b;
    logic [MBF_W+NUM_W-1:0] mul_p;
    logic [NUM_W:0]     rem_shift;
    logic               rem_ge;
    logic [DEM_W-1:0]   demand;
    logic [DEM_W-1:0]   limit_val;
    logic [DEM_W-1:0]   ilace_demand;
    logic [DEM_W-1:0]   ilace_cell;
    logic [14:0]        w_round;
    logic [14:0]        h_round16;
    logic [14:0]        h_round32;

    // macroblock rounding of the incoming picture size
    assign w_round   = {1'b0, pic_width} + 15'd15;
    assign h_round16 = {1'b0, pic_height} + 15'd15;
    assign h_round32 = {1'b0, pic_height} + 15'd31;

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_MUL_FS:
            begin
                mul_a = {{(MBF_W-MB_W){1'b0}}, wmb_reg};
                mul_b = {{(NUM_W-MB_W){1'b0}}, hmb_reg};
            end
            ST_MUL_MBPS:
            begin
                mul_a = mbf_reg;
                mul_b = num_reg;
            end
            default:
            begin
                mul_a = mbf_reg;
                mul_b = {{(NUM_W-REF_W){1'b0}}, refs_reg};
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // restoring divider step
    assign rem_shift = {rem_reg[NUM_W-1:0], dq_reg[PROD_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});

    // demand of the current walk column
    assign ilace_demand = ilace_reg ? DEM_W'(2) : DEM_W'(1);

    always_comb
    begin
        unique case (col_reg)
            COL_ILACE: demand = ilace_demand;
            COL_MBPS:  demand = dq_reg;
            COL_FS:    demand = DEM_W'(mbf_reg);
            COL_DPB:   demand = DEM_W'(dpb_reg);
            COL_VBVR:  demand = DEM_W'(vrate_reg);
            COL_VBVS:  demand = DEM_W'(vsize_reg);
            default:   demand = '0;
        endcase
    end

    // table limit at the walk position, valid while inside the table
    always_comb
    begin
        if (row_reg < ROW_W'(LVL_ROWS) && col_reg < COL_W'(LVL_COLS))
        begin
            limit_val = DEM_W'(LVL_TABLE[row_reg][col_reg]);
        end
        else
        begin
            limit_val = '0;
        end
        if (row_reg < ROW_W'(LVL_ROWS))
        begin
            ilace_cell = DEM_W'(LVL_TABLE[row_reg][COL_ILACE]);
        end
        else
        begin
            ilace_cell = '0;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        wmb_next   = wmb_reg;
        hmb_next   = hmb_reg;
        mbf_next   = mbf_reg;
        dpb_next   = dpb_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        refs_next  = refs_reg;
        ilace_next = ilace_reg;
        vrate_next = vrate_reg;
        vsize_next = vsize_reg;
        cnt_next   = cnt_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        done_next  = 1'b0;
        level_next = level_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // take a new transaction
                if (start)
                begin
                    wmb_next   = w_round[14:4];
                    hmb_next   = is_interlaced ? {h_round32[14:5], 1'b0} : h_round16[14:4];
                    num_next   = rate_num;
                    den_next   = rate_den;
                    refs_next  = ref_count;
                    ilace_next = is_interlaced;
                    vrate_next = vbv_rate;
                    vsize_next = vbv_size;
                    state_next = ST_MUL_FS;
                end
            end
            ST_MUL_FS:
            begin
                mbf_next   = mul_p[MBF_W-1:0];
                state_next = ST_MUL_MBPS;
            end
            ST_MUL_MBPS:
            begin
                dq_next    = mul_p[PROD_W-1:0];
                state_next = ST_MUL_DPB;
            end
            ST_MUL_DPB:
            begin
                // bias the dividend for the ceiling
                dpb_next   = mul_p[DPB_W-1:0];
                dq_next    = dq_reg + PROD_W'(den_reg) - PROD_W'(1);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // one quotient bit per cycle, zero divisor gives all ones
                rem_next = rem_ge ? (rem_shift - {1'b0, den_reg}) : rem_shift;
                dq_next  = {dq_reg[PROD_W-2:0], rem_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    row_next   = '0;
                    col_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // staircase walk, one table entry a cycle
                priority if (row_reg == ROW_W'(LVL_ROWS))
                begin
                    level_next = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (col_reg == COL_W'(LVL_COLS))
                begin
                    level_next = (ilace_demand <= ilace_cell) ?
                                 5'(row_reg) + 5'd1 : 5'd0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (demand > limit_val)
                begin
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wmb_reg   <= '0;
            hmb_reg   <= '0;
            mbf_reg   <= '0;
            dpb_reg   <= '0;
            dq_reg    <= '0;
            rem_reg   <= '0;
            num_reg   <= '0;
            den_reg   <= '0;
            refs_reg  <= '0;
            ilace_reg <= 1'b0;
            vrate_reg <= '0;
            vsize_reg <= '0;
            cnt_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            done_reg  <= 1'b0;
            level_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wmb_reg   <= wmb_next;
            hmb_reg   <= hmb_next;
            mbf_reg   <= mbf_next;
            dpb_reg   <= dpb_next;
            dq_reg    <= dq_next;
            rem_reg   <= rem_next;
            num_reg   <= num_next;
            den_reg   <= den_next;
            refs_reg  <= refs_next;
            ilace_reg <= ilace_next;
            vrate_reg <= vrate_next;
            vsize_reg <= vsize_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            done_reg  <= done_next;
            level_reg <= level_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign level_index = level_reg;

    // checks
    `HALS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
    `HALS_ASSERT_NOW(a_done_idle, done, !busy)
    `HALS_ASSERT_NEXT(a_done_single, done, !done)
    `HALS_ASSERT_NOW(a_level_range, done, level_index <= 5'(LVL_ROWS))

endmodule

[tb/tb_h264_auto_level_select_top.sv]
module tb_h264_auto_level_select_top;

    import hals_pkg::*;

    // one stream setup request as it sits on the ports
    typedef struct packed {
        logic [13:0]       width;
        logic [13:0]       height;
        logic [REF_W-1:0]  refs;
        logic              ilace;
        logic [NUM_W-1:0]  num;
        logic [NUM_W-1:0]  den;
        logic [VBV_W-1:0]  vbv_rate_kbps;
        logic [VBV_W-1:0]  vbv_size_kbit;
    } stream_req_t;

    // h.264 level limits: interlace limit, mbps, frame size, dpb mbs, vbv rate, vbv buffer
    localparam longint unsigned LEVEL_LIMITS [LVL_ROWS][LVL_COLS] = '{
        '{1,    1485,    99,    396,     64,    175},
        '{1,    1485,    99,    396,    128,    350},
        '{1,    3000,   396,    900,    192,    500},
        '{1,    6000,   396,   2376,    384,   1000},
        '{1,   11880,   396,   2376,    768,   2000},
        '{1,   11880,   396,   2376,   2000,   2000},
        '{2,   19800,   792,   4752,   4000,   4000},
        '{2,   20250,  1620,   8100,   4000,   4000},
        '{2,   40500,  1620,   8100,  10000,  10000},
        '{2,  108000,  3600,  18000,  14000,  14000},
        '{2,  216000,  5120,  20480,  20000,  20000},
        '{2,  245760,  8192,  32768,  20000,  25000},
        '{2,  245760,  8192,  32768,  50000,  62500},
        '{2,  522240,  8704,  34816,  50000,  62500},
        '{1,  589824, 22080, 110400, 135000, 135000},
        '{1,  983040, 36864, 184320, 240000, 240000},
        '{1, 2073600, 36864, 184320, 240000, 240000}
    };

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [13:0]       pic_width;
    logic [13:0]       pic_height;
    logic [REF_W-1:0]  ref_count;
    logic              is_interlaced;
    logic [NUM_W-1:0]  rate_num;
    logic [NUM_W-1:0]  rate_den;
    logic [VBV_W-1:0]  vbv_rate;
    logic [VBV_W-1:0]  vbv_size;
    logic              done;
    logic [4:0]        level_index;

    logic [4:0] expected_levels [$];
    int         mismatch_count;
    int         requests_sent;
    int         levels_checked;
    int         level_hits [18];
    int         sender_idle_pct;

    h264_auto_level_select_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .pic_width     (pic_width),
        .pic_height    (pic_height),
        .ref_count     (ref_count),
        .is_interlaced (is_interlaced),
        .rate_num      (rate_num),
        .rate_den      (rate_den),
        .vbv_rate      (vbv_rate),
        .vbv_size      (vbv_size),
        .done          (done),
        .level_index   (level_index)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // level the block should pick for a request
    function automatic logic [4:0] predict_level(stream_req_t req);
        longint unsigned demand [LVL_COLS];
        longint unsigned w;
        longint unsigned h;
        longint unsigned fmul;
        longint unsigned unit;
        longint unsigned mbf;
        longint unsigned prod;
        int row;
        int col;
        w    = 64'(req.width);
        h    = 64'(req.height);
        fmul = req.ilace ? 64'd2 : 64'd1;
        unit = 64'd16 * fmul;
        // field pairs round the height to 32 lines and count two fields
        mbf  = ((w + 64'd15) / 64'd16) * (fmul * ((h + unit - 64'd1) / unit));
        prod = mbf * 64'(req.num);
        demand[COL_ILACE] = fmul;
        // a zero denominator saturates the rate so nothing fits
        if (req.den == '0)
            demand[COL_MBPS] = '1;
        else
            demand[COL_MBPS] = (prod + 64'(req.den) - 64'd1) / 64'(req.den);
        demand[COL_FS]   = mbf;
        demand[COL_DPB]  = mbf * 64'(req.refs);
        demand[COL_VBVR] = 64'(req.vbv_rate_kbps);
        demand[COL_VBVS] = 64'(req.vbv_size_kbit);
        // staircase: step down on overflow, right when the limit holds
        row = 0;
        col = 0;
        while (row < LVL_ROWS && col < LVL_COLS)
        begin
            if (demand[col] > LEVEL_LIMITS[row][col])
                row++;
            else
                col++;
        end
        if (col == LVL_COLS && row < LVL_ROWS
                && demand[COL_ILACE] <= LEVEL_LIMITS[row][COL_ILACE])
            return 5'(row + 1);
        return 5'd0;
    endfunction

    // drive one request and hold it until the block takes it
    task automatic send_request(stream_req_t req);
        int gap;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            gap = $urandom_range(1, 70);
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pic_width     = req.width;
        pic_height    = req.height;
        ref_count     = req.refs;
        is_interlaced = req.ilace;
        rate_num      = req.num;
        rate_den      = req.den;
        vbv_rate      = req.vbv_rate_kbps;
        vbv_size      = req.vbv_size_kbit;
        start         = 1'b1;
        do
            @(posedge clk);
        while (busy);
        expected_levels.push_back(predict_level(req));
        requests_sent++;
    endtask

    task automatic send_stream(int w, int h, int refs, int ilace, int num, int den,
                               int vr, int vs);
        stream_req_t req;
        req.width         = 14'(w);
        req.height        = 14'(h);
        req.refs          = REF_W'(refs);
        req.ilace         = 1'(ilace);
        req.num           = NUM_W'(num);
        req.den           = NUM_W'(den);
        req.vbv_rate_kbps = VBV_W'(vr);
        req.vbv_size_kbit = VBV_W'(vs);
        send_request(req);
    endtask

    // check each answer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_levels.size() == 0)
            begin
                $error("level_index: unexpected result, expected none, actual %0d",
                       level_index);
                mismatch_count++;
            end
            else
            begin
                if (level_index !== expected_levels[0])
                begin
                    $error("level_index: expected %0d, actual %0d",
                           expected_levels[0], level_index);
                    mismatch_count++;
                end
                if (expected_levels[0] <= 17)
                    level_hits[expected_levels[0]]++;
                void'(expected_levels.pop_front());
                levels_checked++;
            end
        end
    end

    // common formats across the level range
    task automatic test_reference_streams();
        send_stream(176, 144, 1, 0, 15, 1, 64, 175);
        send_stream(176, 144, 1, 0, 15, 1, 128, 350);
        send_stream(352, 288, 2, 0, 30000, 1001, 0, 0);
        send_stream(720, 576, 4, 1, 25, 1, 8000, 8000);
        send_stream(1280, 720, 4, 0, 60, 1, 14000, 14000);
        send_stream(1920, 1080, 4, 0, 30, 1, 20000, 25000);
        send_stream(1920, 1080, 4, 1, 30000, 1001, 50000, 62500);
        send_stream(4096, 2304, 3, 0, 60, 1, 240000, 240000);
        send_stream(3840, 2160, 16, 0, 120, 1, 0, 0);
    endtask

    // field extremes and bit patterns
    task automatic test_field_extremes();
        send_stream(1, 1, 1, 0, 1, 1048575, 0, 0);
        send_stream(16383, 16383, 16, 1, 1048575, 1, 16777215, 16777215);
        send_stream(16, 16, 1, 0, 1, 1, 16777215, 0);
        send_stream(16, 16, 1, 0, 1, 1, 0, 16777215);
        send_stream('h2aaa, 'h1555, 'h0a, 1, 'haaaaa, 'h55555, 'haaaaaa, 'h555555);
        send_stream('h1555, 'h2aaa, 'h15, 0, 'h55555, 'haaaaa, 'h555555, 'haaaaaa);
        send_stream(64, 64, 1, 1, 2, 1, 0, 0);
        send_stream(2048, 1024, 1, 1, 1, 2, 0, 0);
    endtask

    // zero denominator, zero size, reference counts outside 1..16
    task automatic test_open_cases();
        send_stream(176, 144, 1, 0, 30, 0, 0, 0);
        send_stream(0, 144, 1, 0, 30, 1, 0, 0);
        send_stream(176, 0, 1, 1, 30, 1, 0, 0);
        send_stream(176, 144, 0, 0, 30, 1, 0, 0);
        send_stream(176, 144, 31, 0, 30, 1, 0, 0);
        send_stream(1920, 1088, 31, 0, 0, 1, 0, 0);
    endtask

    // mostly plausible streams, some raw noise on every bit
    task automatic test_random_streams(int count, int idle_pct);
        stream_req_t req;
        int span;
        int fps;
        sender_idle_pct = idle_pct;
        repeat (count)
        begin
            if ($urandom_range(99) < 25)
            begin
                req.width         = 14'($urandom);
                req.height        = 14'($urandom);
                req.refs          = REF_W'($urandom);
                req.ilace         = 1'($urandom);
                req.num           = NUM_W'($urandom);
                req.den           = NUM_W'($urandom);
                req.vbv_rate_kbps = VBV_W'($urandom);
                req.vbv_size_kbit = VBV_W'($urandom);
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0: span = 64;
                    1: span = 352;
                    2: span = 1280;
                    3: span = 4096;
                    default: span = 16383;
                endcase
                req.width  = 14'($urandom_range(1, span));
                req.height = 14'($urandom_range(1, span));
                req.refs   = REF_W'($urandom_range(1, 16));
                req.ilace  = 1'($urandom_range(0, 1));
                fps        = $urandom_range(1, 120);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        req.den = NUM_W'(1);
                        req.num = NUM_W'(fps);
                    end
                    1:
                    begin
                        req.den = NUM_W'(1001);
                        req.num = NUM_W'(fps * 1000);
                    end
                    default:
                    begin
                        req.den = NUM_W'($urandom_range(1, 2000));
                        req.num = NUM_W'(fps * req.den);
                    end
                endcase
                case ($urandom_range(0, 4))
                    0: span = 0;
                    1: span = 200;
                    2: span = 4000;
                    3: span = 50000;
                    default: span = 300000;
                endcase
                req.vbv_rate_kbps = VBV_W'($urandom_range(0, span));
                req.vbv_size_kbit = VBV_W'($urandom_range(0, span));
            end
            send_request(req);
        end
    endtask

    // stimulus sequence
    initial
    begin
        mismatch_count  = 0;
        requests_sent   = 0;
        levels_checked  = 0;
        sender_idle_pct = 13;
        foreach (level_hits[i])
            level_hits[i] = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        pic_width     = '0;
        pic_height    = '0;
        ref_count     = '0;
        is_interlaced = 1'b0;
        rate_num      = '0;
        rate_den      = '0;
        vbv_rate      = '0;
        vbv_size      = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_reference_streams();
        test_field_extremes();
        test_open_cases();
        test_random_streams(250, 13);
        test_random_streams(250, 65);
        test_random_streams(250, 0);

        @(negedge clk);
        start = 1'b0;
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("summary: %0d requests sent, %0d levels checked", requests_sent,
                 levels_checked);
        $display("summary: outcome counts none=%0d L1=%0d L3=%0d L4=%0d L5.2=%0d",
                 level_hits[0], level_hits[1], level_hits[9], level_hits[12],
                 level_hits[17]);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/hals_pkg.sv
rtl/core/h264_auto_level_select_top.sv
tb/tb_h264_auto_level_select_top.sv
